>>> rtl/zod_pkg.sv
// ---------------------------------------------------------------------------
// zod_pkg
// shared types and constants of the zone occupancy debouncer
// ---------------------------------------------------------------------------
package zod_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_ZONE_LEFT     = 3'd0;
    localparam logic [2:0] REG_ZONE_TOP      = 3'd1;
    localparam logic [2:0] REG_ZONE_WIDTH    = 3'd2;
    localparam logic [2:0] REG_ZONE_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_OVERLAP_RATIO = 3'd4;
    localparam logic [2:0] REG_STABLE_FRAMES = 3'd5;

    localparam int ZONE_BITS   = 11;
    localparam int RATIO_BITS  = 9;
    localparam int STABLE_BITS = 8;
    localparam int CFG_BITS    = 11;

    // reset values of the configuration registers
    localparam logic [ZONE_BITS-1:0]   ZONE_LEFT_RST     = 11'd220;
    localparam logic [ZONE_BITS-1:0]   ZONE_TOP_RST      = 11'd80;
    localparam logic [ZONE_BITS-1:0]   ZONE_WIDTH_RST    = 11'd200;
    localparam logic [ZONE_BITS-1:0]   ZONE_HEIGHT_RST   = 11'd320;
    localparam logic [RATIO_BITS-1:0]  OVERLAP_RATIO_RST = 9'd64;
    localparam logic [STABLE_BITS-1:0] STABLE_FRAMES_RST = 8'd5;

    // saturation value of the stability counter
    localparam logic [STABLE_BITS-1:0] STABLE_CNT_MAX = 8'd255;

    // event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ENTRY = 2'd1;
    localparam logic [1:0] EV_CLEAR = 2'd2;

    // per-frame result from the debouncer
    typedef struct packed {
        logic       frame_hit;
        logic       occupied;
        logic [1:0] event_code;
    } zod_frame_t;

endpackage

>>> rtl/zod_mul.sv
// ---------------------------------------------------------------------------
// zod_mul
// shared unsigned multiplier with registered product
// ---------------------------------------------------------------------------
module zod_mul #(
    parameter int A_BITS = 12,
    parameter int B_BITS = 24
) (
    input  logic                     clk,
    input  logic [A_BITS-1:0]        a,
    input  logic [B_BITS-1:0]        b,
    output logic [A_BITS+B_BITS-1:0] p
);

    logic [A_BITS+B_BITS-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
    end

    assign p = p_reg;

endmodule

>>> rtl/zod_debounce.sv
// ---------------------------------------------------------------------------
// zod_debounce
// end-of-frame occupancy debounce and entry counter
// ---------------------------------------------------------------------------
module zod_debounce #(
    parameter int EVENT_COUNT_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 frame_en,
    input  logic                                 frame_hit,
    input  logic [zod_pkg::STABLE_BITS-1:0]      stable_frames,
    output zod_pkg::zod_frame_t                  frame_next,
    output logic [EVENT_COUNT_BITS-1:0]          entry_next
);

    logic                             cand_reg;
    logic                             cand_next;
    logic [zod_pkg::STABLE_BITS-1:0]  cnt_reg;
    logic [zod_pkg::STABLE_BITS-1:0]  cnt_next;
    logic                             occ_reg;
    logic                             occ_next;
    logic [EVENT_COUNT_BITS-1:0]      entry_reg;
    logic [1:0]                       code_next;

    always_comb
    begin
        cand_next  = cand_reg;
        cnt_next   = cnt_reg;
        occ_next   = occ_reg;
        entry_next = entry_reg;
        code_next  = zod_pkg::EV_NONE;
        if (frame_hit != cand_reg)
        begin
            cand_next = frame_hit;
            cnt_next  = '0;
        end
        else if (cnt_reg != zod_pkg::STABLE_CNT_MAX)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        if ((cnt_next >= stable_frames) && (occ_reg != cand_next))
        begin
            occ_next = cand_next;
            if (cand_next)
            begin
                entry_next = entry_reg + 1'b1;
                code_next  = zod_pkg::EV_ENTRY;
            end
            else
            begin
                code_next = zod_pkg::EV_CLEAR;
            end
        end
        frame_next.frame_hit  = frame_hit;
        frame_next.occupied   = occ_next;
        frame_next.event_code = code_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg  <= 1'b0;
            cnt_reg   <= '0;
            occ_reg   <= 1'b0;
            entry_reg <= '0;
        end
        else if (frame_en)
        begin
            cand_reg  <= cand_next;
            cnt_reg   <= cnt_next;
            occ_reg   <= occ_next;
            entry_reg <= entry_next;
        end
    end

endmodule

>>> rtl/zone_occupancy_debouncer_unit.sv
// ---------------------------------------------------------------------------
// zone_occupancy_debouncer_unit
// zone overlap test of detection boxes with frame-by-frame debounce
// ---------------------------------------------------------------------------
// Each input transaction is a detection box (s_tuser low) or an end-of-frame
// mark (s_tuser high). A box is ordered, intersected with the zone and
// tested with 256 * intersection_area >= overlap_ratio_q8 * box_area, using
// one shared multiplier three times under a small sequencer: a box occupies
// the block through accept, corner ordering, edge clipping, three multiplier
// passes and compare, and s_tready stays low meanwhile. An end of frame
// finishes once the output register is free and produces one output
// transaction; boxes produce none. The output register holds a
// finished frame result while the next boxes are being worked on; a frame
// mark waits only if the previous result has not yet been taken.
// ---------------------------------------------------------------------------
module zone_occupancy_debouncer_unit #(
    parameter int COORD_BITS       = 12,
    parameter int EVENT_COUNT_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [2:0]                            cfg_index,
    input  logic [zod_pkg::CFG_BITS-1:0]          cfg_data,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // box_x_a, box_y_a, box_x_b, box_y_b (lowest first)
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    // action
    input  logic                                  s_tuser,
    // output stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // frame_hit, occupied, event_code, entry_count (lowest first)
    output logic [((4+EVENT_COUNT_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int CB      = COORD_BITS;
    localparam int MB      = 2 * COORD_BITS;          // second multiplier operand
    localparam int PW      = 3 * COORD_BITS;          // product width
    localparam int SW      = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;
    localparam int OUT_W   = 4 + EVENT_COUNT_BITS;
    localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_NORM  = 8'b0000_0010,
        ST_ISECT = 8'b0000_0100,
        ST_MUL_I = 8'b0000_1000,
        ST_MUL_B = 8'b0001_0000,
        ST_MUL_T = 8'b0010_0000,
        ST_CMP   = 8'b0100_0000,
        ST_FRAME = 8'b1000_0000
    } zod_state_t;

    zod_state_t state_reg;
    zod_state_t state_next;

    // configuration registers
    logic [zod_pkg::ZONE_BITS-1:0]   zone_left_reg;
    logic [zod_pkg::ZONE_BITS-1:0]   zone_top_reg;
    logic [zod_pkg::ZONE_BITS-1:0]   zone_width_reg;
    logic [zod_pkg::ZONE_BITS-1:0]   zone_height_reg;
    logic [zod_pkg::RATIO_BITS-1:0]  ratio_reg;
    logic [zod_pkg::STABLE_BITS-1:0] stable_reg;

    // box datapath registers
    logic signed [CB-1:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic signed [CB-1:0] bx0_reg, bx1_reg, by0_reg, by1_reg;
    logic [CB-1:0]        iw_reg, ih_reg, bw_reg, bh_reg;
    logic                 empty_reg;
    logic [MB-1:0]        inter_reg;
    logic                 hit_acc_reg;

    // output register
    logic                        out_valid_reg;
    zod_pkg::zod_frame_t         out_frame_reg;
    logic [EVENT_COUNT_BITS-1:0] out_count_reg;

    // shared multiplier
    logic [CB-1:0] mul_a;
    logic [MB-1:0] mul_b;
    logic [PW-1:0] mul_p;

    // debounce
    logic                        frame_load;
    zod_pkg::zod_frame_t         frame_next;
    logic [EVENT_COUNT_BITS-1:0] entry_next;

    // edge clipping, widened so zone edges and box corners compare as signed
    logic signed [SW-1:0] bx0_e, bx1_e, by0_e, by1_e;
    logic signed [SW-1:0] zx0_e, zx1_e, zy0_e, zy1_e;
    logic signed [SW-1:0] ix_lo, ix_hi, iy_lo, iy_hi;
    logic signed [SW-1:0] iw_s, ih_s, bw_s, bh_s;
    logic                 box_hit;

    assign s_tready   = (state_reg == ST_IDLE);
    // a frame result goes out once the output register is free
    assign frame_load = (state_reg == ST_FRAME) && (!out_valid_reg || m_tready);

    // -------------------------------------------------------------------
    // configuration writes, indexes beyond the list are dropped
    // -------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_left_reg   <= zod_pkg::ZONE_LEFT_RST;
            zone_top_reg    <= zod_pkg::ZONE_TOP_RST;
            zone_width_reg  <= zod_pkg::ZONE_WIDTH_RST;
            zone_height_reg <= zod_pkg::ZONE_HEIGHT_RST;
            ratio_reg       <= zod_pkg::OVERLAP_RATIO_RST;
            stable_reg      <= zod_pkg::STABLE_FRAMES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                zod_pkg::REG_ZONE_LEFT:     zone_left_reg   <= cfg_data;
                zod_pkg::REG_ZONE_TOP:      zone_top_reg    <= cfg_data;
                zod_pkg::REG_ZONE_WIDTH:    zone_width_reg  <= cfg_data;
                zod_pkg::REG_ZONE_HEIGHT:   zone_height_reg <= cfg_data;
                zod_pkg::REG_OVERLAP_RATIO:
                    ratio_reg <= cfg_data[zod_pkg::RATIO_BITS-1:0];
                zod_pkg::REG_STABLE_FRAMES:
                    stable_reg <= cfg_data[zod_pkg::STABLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // -------------------------------------------------------------------
    // sequencer
    // -------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = s_tuser ? ST_FRAME : ST_NORM;
                end
            end
            ST_NORM:  state_next = ST_ISECT;
            ST_ISECT: state_next = ST_MUL_I;
            ST_MUL_I: state_next = ST_MUL_B;
            ST_MUL_B: state_next = ST_MUL_T;
            ST_MUL_T: state_next = ST_CMP;
            ST_CMP:   state_next = ST_IDLE;
            ST_FRAME:
            begin
                if (frame_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // -------------------------------------------------------------------
    // box geometry
    // -------------------------------------------------------------------
    always_comb
    begin
        bx0_e = {{(SW-CB){bx0_reg[CB-1]}}, bx0_reg};
        bx1_e = {{(SW-CB){bx1_reg[CB-1]}}, bx1_reg};
        by0_e = {{(SW-CB){by0_reg[CB-1]}}, by0_reg};
        by1_e = {{(SW-CB){by1_reg[CB-1]}}, by1_reg};
        zx0_e = $signed(SW'(zone_left_reg));
        zy0_e = $signed(SW'(zone_top_reg));
        zx1_e = $signed(SW'(zone_left_reg) + SW'(zone_width_reg));
        zy1_e = $signed(SW'(zone_top_reg) + SW'(zone_height_reg));
        ix_lo = (bx0_e > zx0_e) ? bx0_e : zx0_e;
        ix_hi = (bx1_e < zx1_e) ? bx1_e : zx1_e;
        iy_lo = (by0_e > zy0_e) ? by0_e : zy0_e;
        iy_hi = (by1_e < zy1_e) ? by1_e : zy1_e;
        iw_s  = ix_hi - ix_lo;
        ih_s  = iy_hi - iy_lo;
        bw_s  = bx1_e - bx0_e;
        bh_s  = by1_e - by0_e;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            xa_reg <= $signed(s_tdata[CB-1:0]);
            ya_reg <= $signed(s_tdata[2*CB-1:CB]);
            xb_reg <= $signed(s_tdata[3*CB-1:2*CB]);
            yb_reg <= $signed(s_tdata[4*CB-1:3*CB]);
        end
        if (state_reg == ST_NORM)
        begin
            // swapped corners put in order
            bx0_reg <= (xa_reg < xb_reg) ? xa_reg : xb_reg;
            bx1_reg <= (xa_reg < xb_reg) ? xb_reg : xa_reg;
            by0_reg <= (ya_reg < yb_reg) ? ya_reg : yb_reg;
            by1_reg <= (ya_reg < yb_reg) ? yb_reg : ya_reg;
        end
        if (state_reg == ST_ISECT)
        begin
            // negative overlap clipped to zero
            iw_reg    <= iw_s[SW-1] ? '0 : iw_s[CB-1:0];
            ih_reg    <= ih_s[SW-1] ? '0 : ih_s[CB-1:0];
            bw_reg    <= bw_s[CB-1:0];
            bh_reg    <= bh_s[CB-1:0];
            // an empty intersection also covers the empty box
            empty_reg <= (iw_s[SW-1] || (iw_s == '0) || ih_s[SW-1] || (ih_s == '0));
        end
        if (state_reg == ST_MUL_B)
        begin
            inter_reg <= mul_p[MB-1:0];
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_I:
            begin
                mul_a = iw_reg;
                mul_b = MB'(ih_reg);
            end
            ST_MUL_B:
            begin
                mul_a = bw_reg;
                mul_b = MB'(bh_reg);
            end
            ST_MUL_T:
            begin
                // product now holds the box area
                mul_a = CB'(ratio_reg);
                mul_b = mul_p[MB-1:0];
            end
            default: ;
        endcase
    end

    zod_mul #(
        .A_BITS (CB),
        .B_BITS (MB)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // 256 * intersection against threshold * box area
    assign box_hit = empty_reg ? (ratio_reg == '0)
                               : (PW'({inter_reg, 8'h00}) >= mul_p);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_acc_reg <= 1'b0;
        end
        else if ((state_reg == ST_CMP) && box_hit)
        begin
            hit_acc_reg <= 1'b1;
        end
        else if (frame_load)
        begin
            hit_acc_reg <= 1'b0;
        end
    end

    // -------------------------------------------------------------------
    // end of frame debounce and output register
    // -------------------------------------------------------------------
    zod_debounce #(
        .EVENT_COUNT_BITS (EVENT_COUNT_BITS)
    ) u_debounce (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_en      (frame_load),
        .frame_hit     (hit_acc_reg),
        .stable_frames (stable_reg),
        .frame_next    (frame_next),
        .entry_next    (entry_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_frame_reg <= '0;
            out_count_reg <= '0;
        end
        else if (frame_load)
        begin
            out_valid_reg <= 1'b1;
            out_frame_reg <= frame_next;
            out_count_reg <= entry_next;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'({out_count_reg, out_frame_reg.event_code,
                               out_frame_reg.occupied, out_frame_reg.frame_hit});

`ifndef SYNTHESIS
    // a result only appears out of the frame state
    a_out_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FRAME))
        else $error("output valid without a frame transaction");

    // an entry event always reports the zone as occupied
    a_entry_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_frame_reg.event_code == zod_pkg::EV_ENTRY))
            |-> out_frame_reg.occupied)
        else $error("entry event with zone not occupied");

    // the entry count moves only together with an entry event
    a_count_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_count_reg != $past(out_count_reg))
            |-> (out_frame_reg.event_code == zod_pkg::EV_ENTRY))
        else $error("entry count changed without entry event");

    // the hit accumulator starts empty after each frame
    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        frame_load |=> !hit_acc_reg)
        else $error("hit accumulator not cleared at end of frame");
`endif

endmodule

>>> sim/zone_occupancy_debouncer_unit_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// zone_occupancy_debouncer_unit_test
// self-checking bench for the zone overlap and frame debounce unit
// ---------------------------------------------------------------------------
// Detection boxes and end-of-frame marks are streamed into the unit in random
// bursts while the result side stalls on its own pattern. Every accepted
// input transaction goes through a local model of the overlap test and the
// debounce, and each end-of-frame leaves a frame verdict in a queue. Output
// transactions are checked field by field against the oldest verdict. The
// run moves through several zone and threshold settings, written only while
// the unit is idle.
// ---------------------------------------------------------------------------
module zone_occupancy_debouncer_unit_test;

    localparam int COORD_BITS     = 12;
    localparam int EVENT_BITS     = 32;
    localparam int S_DATA_BITS    = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS    = ((4 + EVENT_BITS + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 2000;
    // a box keeps the unit busy through its sequencer steps, so this covers any work in flight
    localparam int SETTLE_CYCLES  = 16;

    // action codes carried on s_tuser
    localparam logic ACT_BOX       = 1'b0;
    localparam logic ACT_FRAME_END = 1'b1;

    // register indexes past the end of the map, writes there are dropped
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // kinds of generated box
    localparam int BOX_INSIDE = 0;
    localparam int BOX_NEAR   = 1;
    localparam int BOX_FLAT   = 2;
    localparam int BOX_WILD   = 3;

    // result-side stall styles
    localparam int RX_OPEN = 0;
    localparam int RX_COIN = 1;
    localparam int RX_LONG = 2;

    typedef struct {
        logic                   action;
        logic [COORD_BITS-1:0]  x_a;
        logic [COORD_BITS-1:0]  y_a;
        logic [COORD_BITS-1:0]  x_b;
        logic [COORD_BITS-1:0]  y_b;
    } detection_t;

    // laid out exactly as the low bits of m_tdata
    typedef struct packed {
        logic [EVENT_BITS-1:0] entry_count;
        logic [1:0]            event_code;
        logic                  occupied;
        logic                  frame_hit;
    } frame_verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [zod_pkg::CFG_BITS-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_BITS-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;

    zone_occupancy_debouncer_unit #(
        .COORD_BITS       (COORD_BITS),
        .EVENT_COUNT_BITS (EVENT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // box_x_a, box_y_a, box_x_b, box_y_b (lowest first)
        .s_tuser   (s_tuser),      // action
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)       // frame_hit, occupied, event_code, entry_count
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // -----------------------------------------------------------------------
    // local copy of the register map and of the debounce state
    // -----------------------------------------------------------------------
    logic [zod_pkg::ZONE_BITS-1:0]   zone_left   = zod_pkg::ZONE_LEFT_RST;
    logic [zod_pkg::ZONE_BITS-1:0]   zone_top    = zod_pkg::ZONE_TOP_RST;
    logic [zod_pkg::ZONE_BITS-1:0]   zone_width  = zod_pkg::ZONE_WIDTH_RST;
    logic [zod_pkg::ZONE_BITS-1:0]   zone_height = zod_pkg::ZONE_HEIGHT_RST;
    logic [zod_pkg::RATIO_BITS-1:0]  ratio_q8    = zod_pkg::OVERLAP_RATIO_RST;
    logic [zod_pkg::STABLE_BITS-1:0] stable_need = zod_pkg::STABLE_FRAMES_RST;

    logic                            hit_seen     = 1'b0;
    logic                            candidate    = 1'b0;
    logic [zod_pkg::STABLE_BITS-1:0] stable_count = '0;
    logic                            occupied_now = 1'b0;
    logic [EVENT_BITS-1:0]           entries      = '0;

    detection_t     detection_feed[$];
    frame_verdict_t frame_verdicts_due[$];

    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  in_fire = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  rx_style = RX_OPEN;
    int  rx_style_age = 0;

    // overlap test: corners put in order, box clipped against the zone, and
    // 256 * intersection >= ratio * box area decided without a division
    function automatic logic box_is_hit(input logic signed [COORD_BITS-1:0] xa,
                                        input logic signed [COORD_BITS-1:0] ya,
                                        input logic signed [COORD_BITS-1:0] xb,
                                        input logic signed [COORD_BITS-1:0] yb);
        longint bx0, bx1, by0, by1, zx0, zy0, zx1, zy1, iw, ih;
        longint box_area, clip_area;
        bx0 = longint'((xa < xb) ? xa : xb);
        bx1 = longint'((xa < xb) ? xb : xa);
        by0 = longint'((ya < yb) ? ya : yb);
        by1 = longint'((ya < yb) ? yb : ya);
        zx0 = longint'(zone_left);
        zy0 = longint'(zone_top);
        zx1 = zx0 + longint'(zone_width);
        zy1 = zy0 + longint'(zone_height);
        iw = ((bx1 < zx1) ? bx1 : zx1) - ((bx0 > zx0) ? bx0 : zx0);
        ih = ((by1 < zy1) ? by1 : zy1) - ((by0 > zy0) ? by0 : zy0);
        if (iw < 0)
            iw = 0;
        if (ih < 0)
            ih = 0;
        box_area = (bx1 - bx0) * (by1 - by0);
        clip_area = iw * ih;
        // nothing overlapping counts as ratio zero
        if (clip_area == 0 || box_area == 0)
            return ratio_q8 == '0;
        return clip_area * 256 >= longint'(ratio_q8) * box_area;
    endfunction

    // end of frame: debounce the frame's hit and build its verdict
    function automatic frame_verdict_t close_frame();
        frame_verdict_t v;
        v.frame_hit = hit_seen;
        v.event_code = zod_pkg::EV_NONE;
        if (hit_seen != candidate)
        begin
            candidate = hit_seen;
            stable_count = '0;
        end
        else if (stable_count != zod_pkg::STABLE_CNT_MAX)
        begin
            stable_count = stable_count + 1'b1;
        end
        if (stable_count >= stable_need && occupied_now != candidate)
        begin
            occupied_now = candidate;
            if (occupied_now)
            begin
                entries = entries + 1'b1;
                v.event_code = zod_pkg::EV_ENTRY;
            end
            else
            begin
                v.event_code = zod_pkg::EV_CLEAR;
            end
        end
        hit_seen = 1'b0;
        v.occupied = occupied_now;
        v.entry_count = entries;
        return v;
    endfunction

    // -----------------------------------------------------------------------
    // stimulus helpers
    // -----------------------------------------------------------------------
    function automatic int roll(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clamp_coord(input int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    function automatic void queue_box(input int xa, input int ya, input int xb, input int yb);
        detection_t d;
        d.action = ACT_BOX;
        d.x_a = xa[COORD_BITS-1:0];
        d.y_a = ya[COORD_BITS-1:0];
        d.x_b = xb[COORD_BITS-1:0];
        d.y_b = yb[COORD_BITS-1:0];
        detection_feed = {detection_feed, d};
    endfunction

    // the coordinate fields still carry random bits on a frame mark
    function automatic void queue_frame_end();
        detection_t d;
        d.action = ACT_FRAME_END;
        d.x_a = COORD_BITS'($urandom);
        d.y_a = COORD_BITS'($urandom);
        d.x_b = COORD_BITS'($urandom);
        d.y_b = COORD_BITS'($urandom);
        detection_feed = {detection_feed, d};
    endfunction

    function automatic void queue_random_box(input int style);
        int xa, ya, xb, yb, zl, zt, zw, zh;
        zl = int'(zone_left);
        zt = int'(zone_top);
        zw = int'(zone_width);
        zh = int'(zone_height);
        case (style)
            BOX_INSIDE:
            begin
                xa = zl + roll(0, zw);
                xb = zl + roll(0, zw);
                ya = zt + roll(0, zh);
                yb = zt + roll(0, zh);
            end
            BOX_NEAR:
            begin
                xa = zl + roll(-64, zw + 64);
                xb = zl + roll(-64, zw + 64);
                ya = zt + roll(-64, zh + 64);
                yb = zt + roll(-64, zh + 64);
            end
            BOX_FLAT:
            begin
                xa = zl + roll(-8, zw + 8);
                xb = xa;
                ya = zt + roll(-8, zh + 8);
                yb = zt + roll(-8, zh + 8);
                if ($urandom_range(0, 1))
                    yb = ya;
            end
            default:
            begin
                xa = roll(-2048, 2047);
                xb = roll(-2048, 2047);
                ya = roll(-2048, 2047);
                yb = roll(-2048, 2047);
            end
        endcase
        queue_box(clamp_coord(xa), clamp_coord(ya), clamp_coord(xb), clamp_coord(yb));
    endfunction

    // runs of busy and quiet frames so the debounce gets to settle both ways;
    // quiet runs still carry some stray boxes
    task automatic queue_random_frames(input int quota);
        int  made;
        int  run_len;
        int  n_boxes;
        int  pick;
        bit  busy_run;
        made = 0;
        while (made < quota)
        begin
            busy_run = 1'($urandom_range(0, 1));
            run_len = roll(1, 8);
            repeat (run_len)
            begin
                n_boxes = busy_run ? roll(1, 4) : roll(0, 2);
                repeat (n_boxes)
                begin
                    pick = roll(0, 9);
                    if (busy_run && pick < 6)
                        queue_random_box(BOX_INSIDE);
                    else if (pick < 8)
                        queue_random_box(BOX_NEAR);
                    else if (pick < 9)
                        queue_random_box(BOX_WILD);
                    else
                        queue_random_box(BOX_FLAT);
                    made++;
                end
                queue_frame_end();
                made++;
            end
        end
    endtask

    // register write at a falling edge, the local copy follows it
    task automatic write_reg(input logic [2:0] idx,
                             input logic [zod_pkg::CFG_BITS-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            zod_pkg::REG_ZONE_LEFT:     zone_left = val[zod_pkg::ZONE_BITS-1:0];
            zod_pkg::REG_ZONE_TOP:      zone_top = val[zod_pkg::ZONE_BITS-1:0];
            zod_pkg::REG_ZONE_WIDTH:    zone_width = val[zod_pkg::ZONE_BITS-1:0];
            zod_pkg::REG_ZONE_HEIGHT:   zone_height = val[zod_pkg::ZONE_BITS-1:0];
            zod_pkg::REG_OVERLAP_RATIO: ratio_q8 = val[zod_pkg::RATIO_BITS-1:0];
            zod_pkg::REG_STABLE_FRAMES: stable_need = val[zod_pkg::STABLE_BITS-1:0];
            default:                    ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_zone(input int l, input int t, input int w, input int h,
                            input int ratio, input int need);
        write_reg(zod_pkg::REG_ZONE_LEFT, l[zod_pkg::CFG_BITS-1:0]);
        write_reg(zod_pkg::REG_ZONE_TOP, t[zod_pkg::CFG_BITS-1:0]);
        write_reg(zod_pkg::REG_ZONE_WIDTH, w[zod_pkg::CFG_BITS-1:0]);
        write_reg(zod_pkg::REG_ZONE_HEIGHT, h[zod_pkg::CFG_BITS-1:0]);
        write_reg(zod_pkg::REG_OVERLAP_RATIO, ratio[zod_pkg::CFG_BITS-1:0]);
        write_reg(zod_pkg::REG_STABLE_FRAMES, need[zod_pkg::CFG_BITS-1:0]);
    endtask

    // the sender holds off here until every verdict is back, then lets a box
    // still being worked on run out before anything is reconfigured
    task automatic wait_for_quiet();
        while (detection_feed.size() != 0 || s_tvalid || frame_verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic flag_mismatch(input string field_name, input logic [EVENT_BITS-1:0] want,
                                 input logic [EVENT_BITS-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d", field_name, want, got);
    endtask

    // -----------------------------------------------------------------------
    // driver: one transaction per handshake, bursts separated by gaps
    // -----------------------------------------------------------------------
    always @(negedge clk)
    begin
        detection_t d;
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (detection_feed.size() > 0)
            begin
                d = detection_feed.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= d.action;
                s_tdata <= {d.y_b, d.x_b, d.y_a, d.x_a};
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = roll(1, 16);
                    // about a quarter of bursts run straight into the next one
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : roll(1, 8);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side: open, coin-flip, or occasional long stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                RX_OPEN:
                    m_tready <= 1'b1;
                RX_COIN:
                    m_tready <= 1'($urandom_range(0, 1));
                default:
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left = roll(1, 20);
                        m_tready <= 1'b0;
                    end
                    else
                    begin
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
        rx_style_age++;
        if (rx_style_age >= 256)
        begin
            rx_style_age = 0;
            rx_style = roll(RX_OPEN, RX_LONG);
        end
    end

    // -----------------------------------------------------------------------
    // monitor: model update on input handshakes, check on output handshakes
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        frame_verdict_t want;
        frame_verdict_t got;
        in_fire = s_tvalid && s_tready;
        if (in_fire)
        begin
            if (s_tuser == ACT_BOX)
            begin
                if (box_is_hit(s_tdata[11:0], s_tdata[23:12], s_tdata[35:24], s_tdata[47:36]))
                    hit_seen = 1'b1;
            end
            else
            begin
                want = close_frame();
                frame_verdicts_due = {frame_verdicts_due, want};
            end
        end

        if (m_tvalid && m_tready)
        begin
            got = frame_verdict_t'(m_tdata[35:0]);
            if (frame_verdicts_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("frame result with nothing pending: %h", m_tdata);
            end
            else
            begin
                want = frame_verdicts_due.pop_front();
                if (got.frame_hit !== want.frame_hit)
                    flag_mismatch("frame_hit", EVENT_BITS'(want.frame_hit),
                                  EVENT_BITS'(got.frame_hit));
                if (got.occupied !== want.occupied)
                    flag_mismatch("occupied", EVENT_BITS'(want.occupied),
                                  EVENT_BITS'(got.occupied));
                if (got.event_code !== want.event_code)
                    flag_mismatch("event_code", EVENT_BITS'(want.event_code),
                                  EVENT_BITS'(got.event_code));
                if (got.entry_count !== want.entry_count)
                    flag_mismatch("entry_count", want.entry_count, got.entry_count);
            end
        end

        // watchdog on cycles without any transaction or register write
        if (in_fire || (m_tvalid && m_tready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // test sequence
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zone x 220..419, y 80..399, quarter overlap, 5 frames
        // six hit frames in a row give an entry
        queue_box(240, 100, 300, 200);
        queue_frame_end();
        queue_box(300, 200, 240, 100);          // swapped corners
        queue_frame_end();
        queue_box(145, 80, 245, 180);           // exactly a quarter inside
        queue_frame_end();
        queue_box(144, 80, 244, 180);           // just under a quarter
        queue_box(250, 90, 260, 95);
        queue_frame_end();
        queue_box(2047, 2047, 2047, 2047);
        queue_box(219, 79, 221, 81);
        queue_frame_end();
        queue_box(400, 390, 430, 410);
        queue_frame_end();
        // then a run of misses
        queue_box(-2048, -2048, 2047, 2047);    // full coordinate range
        queue_frame_end();
        queue_box(2047, 2047, -2048, -2048);
        queue_frame_end();
        queue_box(250, 100, 250, 200);          // empty box
        queue_frame_end();
        queue_box(-2048, -2048, -1000, -1000);  // no intersection
        queue_frame_end();
        queue_frame_end();                      // frame with no boxes
        wait_for_quiet();

        // whole map, zero threshold, no debounce: any box counts, even an empty
        // one; spare indexes get written and must change nothing
        set_zone(0, 0, 2047, 2047, 0, 0);
        write_reg(REG_SPARE_LO, 11'h7FF);
        write_reg(REG_SPARE_HI, 11'h555);
        queue_box(100, 100, 100, 100);
        queue_frame_end();
        queue_frame_end();
        queue_box(-2048, -2048, -2047, -2047);
        queue_frame_end();
        queue_random_frames(40);
        wait_for_quiet();

        // zone pushed off the far corner, threshold beyond one, longest
        // debounce: a long quiet stretch saturates the stability counter
        write_reg(zod_pkg::REG_ZONE_LEFT, 11'h7FF);
        write_reg(zod_pkg::REG_ZONE_TOP, 11'h7FF);
        write_reg(zod_pkg::REG_ZONE_WIDTH, 11'h7FF);
        write_reg(zod_pkg::REG_ZONE_HEIGHT, 11'h7FF);
        write_reg(zod_pkg::REG_OVERLAP_RATIO, 11'h7FF);
        write_reg(zod_pkg::REG_STABLE_FRAMES, 11'h7FF);
        queue_box(2046, 2046, 2047, 2047);
        queue_frame_end();
        repeat (270) queue_frame_end();
        queue_random_frames(10);
        wait_for_quiet();

        // full-overlap threshold: only boxes wholly inside the zone hit
        set_zone(roll(0, 600), roll(0, 600), roll(1, 600), roll(1, 600), 256, 0);
        queue_box(int'(zone_left), int'(zone_top), int'(zone_left) + int'(zone_width),
                  int'(zone_top) + int'(zone_height));
        queue_frame_end();
        queue_box(int'(zone_left) - 1, int'(zone_top), int'(zone_left) + int'(zone_width),
                  int'(zone_top) + int'(zone_height));
        queue_frame_end();
        queue_random_frames(30);
        wait_for_quiet();

        // assorted random settings, one with a threshold just past one
        for (int phase = 0; phase < 4; phase++)
        begin
            set_zone(roll(0, 600), roll(0, 600), roll(0, 600), roll(0, 600),
                     (phase == 3) ? 257 : roll(0, 256), roll(0, 4));
            queue_random_frames(20);
            wait_for_quiet();
        end

        if (frame_verdicts_due.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
